// File: rtl/iprx_pkg.sv
package iprx_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } rx_byte_t;

  typedef enum logic [2:0] {
    VERDICT_ICMP        = 3'd0,
    VERDICT_UDP         = 3'd1,
    VERDICT_TCP         = 3'd2,
    VERDICT_FRAME_SHORT = 3'd3,
    VERDICT_BAD_IHL     = 3'd4,
    VERDICT_BAD_TOTAL   = 3'd5,
    VERDICT_NOT_OURS    = 3'd6,
    VERDICT_IGNORED     = 3'd7
  } verdict_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [5:0]  payload_offset;
    logic [15:0] payload_length;
  } rx_result_t;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [3:0]  header_words;
    logic [15:0] total_length;
    logic [7:0]  protocol_number;
    logic [31:0] destination_address;
  } frame_summary_t;

  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
  localparam logic [15:0] IDX_VER_IHL     = 16'd0;
  localparam logic [15:0] IDX_LEN_HI      = 16'd2;
  localparam logic [15:0] IDX_LEN_LO      = 16'd3;
  localparam logic [15:0] IDX_PROTO       = 16'd9;
  localparam logic [15:0] IDX_DST_FIRST   = 16'd16;
  localparam logic [15:0] IDX_DST_LAST    = 16'd19;
  localparam logic [7:0]  IHL_MASK        = 8'h0F;
  localparam logic [15:0] MIN_FRAME_BYTES = 16'd20;
  localparam logic [3:0]  MIN_IHL         = 4'd5;
  localparam logic [5:0]  MIN_HDR_BYTES   = 6'd20;
  localparam logic [31:0] BROADCAST_ADDR  = 32'hFFFFFFFF;
  localparam logic [7:0]  PROTO_ICMP      = 8'd1;
  localparam logic [7:0]  PROTO_TCP       = 8'd6;
  localparam logic [7:0]  PROTO_UDP       = 8'd17;
  localparam logic [15:0] ICMP_MIN        = 16'd8;
  localparam logic [15:0] UDP_MIN         = 16'd8;
  localparam logic [15:0] TCP_MIN         = 16'd20;

endpackage

// File: rtl/iprx_front.sv
module iprx_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  iprx_pkg::rx_byte_t      in_data,
  output logic                    in_stall,
  input  logic                    queue_full,
  output logic                    push,
  output iprx_pkg::frame_summary_t push_data
);
  import iprx_pkg::*;

  logic [15:0] byte_count;
  logic [15:0] count_inc;
  logic [3:0]  header_words;
  logic [3:0]  header_words_next;
  logic [15:0] total_length;
  logic [15:0] total_length_next;
  logic [7:0]  protocol_number;
  logic [7:0]  protocol_number_next;
  logic [31:0] destination_address;
  logic [31:0] destination_address_next;
  logic        accept;

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;
  assign count_inc = (byte_count == COUNT_MAX) ? COUNT_MAX : byte_count + 16'd1;

  always_comb begin
    header_words_next        = header_words;
    total_length_next        = total_length;
    protocol_number_next     = protocol_number;
    destination_address_next = destination_address;
    case (byte_count)
      IDX_VER_IHL: begin
        header_words_next = 4'(in_data.data_byte & IHL_MASK);
      end
      IDX_LEN_HI: begin
        total_length_next = {in_data.data_byte, total_length[7:0]};
      end
      IDX_LEN_LO: begin
        total_length_next = {total_length[15:8], in_data.data_byte};
      end
      IDX_PROTO: begin
        protocol_number_next = in_data.data_byte;
      end
      default: begin
      end
    endcase
    if (byte_count inside {[IDX_DST_FIRST:IDX_DST_LAST]}) begin
      destination_address_next = {destination_address[23:0], in_data.data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (accept) begin
      byte_count <= in_data.last_byte ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      header_words        <= header_words_next;
      total_length        <= total_length_next;
      protocol_number     <= protocol_number_next;
      destination_address <= destination_address_next;
    end
  end

  assign push = accept && in_data.last_byte;

  always_comb begin
    push_data.frame_length        = count_inc;
    push_data.header_words        = header_words_next;
    push_data.total_length        = total_length_next;
    push_data.protocol_number     = protocol_number_next;
    push_data.destination_address = destination_address_next;
  end

  // A frame that has ended leaves the counter ready for the next one.
  assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.last_byte) |=> (byte_count == '0))
    else $error("byte count not cleared after final byte");

endmodule

// File: rtl/iprx_queue.sv
module iprx_queue #(
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  iprx_pkg::frame_summary_t push_data,
  input  logic                     pop,
  output logic                     head_valid,
  output iprx_pkg::frame_summary_t head_data,
  output logic                     full
);
  import iprx_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_summary_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");

  assert property (@(posedge clk) disable iff (rst) !(pop && !head_valid))
    else $error("pop from empty queue");

endmodule

// File: rtl/iprx_back.sv
module iprx_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write_enable,
  input  logic [31:0]              cfg_write_data,
  input  logic                     head_valid,
  input  iprx_pkg::frame_summary_t head_data,
  output logic                     pop,
  output logic                     out_valid,
  output iprx_pkg::rx_result_t     out_data,
  input  logic                     out_stall
);
  import iprx_pkg::*;

  logic [31:0] local_address;
  logic [5:0]  header_bytes;
  logic [15:0] payload_len;
  rx_result_t  result;
  logic        out_valid_next;
  logic        accepted_type;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_address <= '0;
    end else if (cfg_write_enable) begin
      local_address <= cfg_write_data;
    end
  end

  assign header_bytes = {head_data.header_words, 2'b00};
  assign payload_len  = head_data.total_length - {10'd0, header_bytes};

  always_comb begin
    result.verdict        = VERDICT_IGNORED;
    result.payload_offset = '0;
    result.payload_length = '0;
    if (head_data.frame_length < MIN_FRAME_BYTES) begin
      result.verdict = VERDICT_FRAME_SHORT;
    end else if (head_data.header_words < MIN_IHL) begin
      result.verdict = VERDICT_BAD_IHL;
    end else if (head_data.total_length < {10'd0, header_bytes} ||
                 head_data.total_length > head_data.frame_length) begin
      result.verdict = VERDICT_BAD_TOTAL;
    end else if (head_data.destination_address != local_address &&
                 head_data.destination_address != BROADCAST_ADDR) begin
      result.verdict = VERDICT_NOT_OURS;
    end else if (head_data.protocol_number == PROTO_ICMP && payload_len >= ICMP_MIN) begin
      result.verdict        = VERDICT_ICMP;
      result.payload_offset = header_bytes;
      result.payload_length = payload_len;
    end else if (head_data.protocol_number == PROTO_UDP && payload_len >= UDP_MIN) begin
      result.verdict        = VERDICT_UDP;
      result.payload_offset = header_bytes;
      result.payload_length = payload_len;
    end else if (head_data.protocol_number == PROTO_TCP && payload_len >= TCP_MIN) begin
      result.verdict        = VERDICT_TCP;
      result.payload_offset = header_bytes;
      result.payload_length = payload_len;
    end
  end

  assign pop            = head_valid && (!out_valid || !out_stall);
  assign out_valid_next = pop || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= result;
    end
  end

  assign accepted_type = (out_data.verdict == VERDICT_ICMP) ||
                         (out_data.verdict == VERDICT_UDP) ||
                         (out_data.verdict == VERDICT_TCP);

  // A delivered packet always carries at least a minimal header.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && accepted_type) |-> (out_data.payload_offset >= MIN_HDR_BYTES))
    else $error("delivered packet with short header offset");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !accepted_type) |->
      (out_data.payload_offset == '0 && out_data.payload_length == '0))
    else $error("rejected packet with nonzero payload fields");

endmodule

// File: rtl/ipv4_rx_header_filter_top.sv
// IPv4 receive header filter.
// The input channel takes one byte of an IPv4 packet per request, starting
// at the first header byte, with last_byte set on the final byte of the frame.
// The output channel gives one request per frame: the verdict, the payload
// offset and the payload length. The local address register is written
// through cfg_write_enable and cfg_write_data; the user must write it only
// while no frame is in flight, as the block itself does not enforce this.
// Throughput is one byte per clock for as long as the summary queue has room.
// A frame summary enters the queue on the edge that takes the final byte, and
// its result is registered from the queue head when the output is free.
// The queue holds QUEUE_DEPTH frame summaries between the byte capture and the
// checking stage; while the receiver stalls, results wait in the output
// register and the queue, and once the queue is full the input is stalled.
// Synchronous reset clears the byte counter, the queue, the output valid and
// the local address, which becomes zero.
module ipv4_rx_header_filter_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_enable,
  input  logic [31:0]          cfg_write_data,
  input  logic                 in_valid,
  input  iprx_pkg::rx_byte_t   in_data,
  output logic                 in_stall,
  output logic                 out_valid,
  output iprx_pkg::rx_result_t out_data,
  input  logic                 out_stall
);
  import iprx_pkg::*;

  logic           queue_full;
  logic           push;
  frame_summary_t push_data;
  logic           pop;
  logic           head_valid;
  frame_summary_t head_data;

  iprx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  iprx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .full       (queue_full)
  );

  iprx_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .head_valid       (head_valid),
    .head_data        (head_data),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_data         (out_data),
    .out_stall        (out_stall)
  );

endmodule
